// ===== hdl/cpp_pkg.sv =====
// shared types and widths for the collider push-out block
// used by every module under hdl, no dependencies
package cpp_pkg;

	localparam int CPP_ROOT_W = 34;
	localparam int CPP_NUM_W  = 64;
	localparam int CPP_DEN_W  = 34;
	localparam int CPP_QUO_W  = 32;

	typedef enum logic [2:0] {
		REG_SHAPE_MODE    = 3'd0,
		REG_MARGIN        = 3'd1,
		REG_CENTER_X      = 3'd2,
		REG_CENTER_Y      = 3'd3,
		REG_CENTER_Z      = 3'd4,
		REG_SPHERE_RADIUS = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] push_x;
		logic signed [31:0] push_y;
		logic signed [31:0] push_z;
		logic               in_contact;
		logic               at_center;
	} result_t;

endpackage

// ===== hdl/collider_penetration_pushout.sv =====
// collider push-out top level: sphere / ground plane correction vector
// depends on cpp_pkg, cpp_isqrt, cpp_div
//
//  channel  | handshake            | word
//  ---------+----------------------+-------------------------------------
//  command  | start / busy         | cmd_t: pos_x, pos_y, pos_z
//  result   | done (one cycle)     | result_t: push_x/y/z, in_contact,
//           |                      |           at_center
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one word is taken every cycle; busy stays low
// each result follows its command through the registered stages, among them the
// 34 root stages of the square root and the 32 quotient stages of the divider
// the receiver cannot stall, so nothing in the pipeline ever holds
// reset clears the valid bits and loads the register defaults
// (plane mode, margin 0, center 0, radius 1.0)
module collider_penetration_pushout import cpp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  cmd_t        cmd,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output result_t     result
);
	// side data riding along the square root
	typedef struct packed {
		logic        mode;
		logic        plane_lt;
		logic [31:0] plane_y;
		logic        at_ctr;
		logic [2:0]  neg;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] mag_z;
	} sq_side_t;

	// side data riding along the dividers
	typedef struct packed {
		logic        mode;
		logic        plane_lt;
		logic [31:0] plane_y;
		logic        at_ctr;
		logic        lt;
		logic [2:0]  neg;
	} dv_side_t;

	// configuration registers
	logic               mode_q;
	logic [30:0]        margin_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0]        srad_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b1;
			margin_q <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			cz_q     <= '0;
			srad_q   <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_SHAPE_MODE:    mode_q   <= cfg_data[0];
				REG_MARGIN:        margin_q <= cfg_data[30:0];
				REG_CENTER_X:      cx_q     <= cfg_data;
				REG_CENTER_Y:      cy_q     <= cfg_data;
				REG_CENTER_Z:      cz_q     <= cfg_data;
				REG_SPHERE_RADIUS: srad_q   <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// stage 1: offsets from the center and the plane test
	logic signed [32:0] dx, dy, dz, my, py, pv;
	logic               acc;
	assign acc = start && !busy;

	always_comb begin
		dx = {cmd.pos_x[31], cmd.pos_x} - {cx_q[31], cx_q};
		dy = {cmd.pos_y[31], cmd.pos_y} - {cy_q[31], cy_q};
		dz = {cmd.pos_z[31], cmd.pos_z} - {cz_q[31], cz_q};
		my = {2'b00, margin_q};
		py = {cmd.pos_y[31], cmd.pos_y};
		pv = my - py;
	end

	logic        v_s1;
	sq_side_t    sd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		sd_s1.mode     <= mode_q;
		sd_s1.plane_lt <= (py < my);
		// lift saturates at the top of the signed range
		sd_s1.plane_y  <= (pv[32:31] != 2'b00) ? 32'h7FFF_FFFF : pv[31:0];
		sd_s1.at_ctr   <= (dx == '0) && (dy == '0) && (dz == '0);
		sd_s1.neg      <= {dx[32], dy[32], dz[32]};
		sd_s1.mag_x    <= dx[32] ? 32'(-dx) : dx[31:0];
		sd_s1.mag_y    <= dy[32] ? 32'(-dy) : dy[31:0];
		sd_s1.mag_z    <= dz[32] ? 32'(-dz) : dz[31:0];
	end

	// stage 2: squares
	logic        v_s2;
	sq_side_t    sd_s2;
	logic [63:0] sqx_s2, sqy_s2, sqz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sd_s2  <= sd_s1;
		sqx_s2 <= sd_s1.mag_x * sd_s1.mag_x;
		sqy_s2 <= sd_s1.mag_y * sd_s1.mag_y;
		sqz_s2 <= sd_s1.mag_z * sd_s1.mag_z;
	end

	// stage 3: sum of squares
	logic        v_s3;
	sq_side_t    sd_s3;
	logic [65:0] sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		sd_s3  <= sd_s2;
		sum_s3 <= {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	end

	// distance by square root
	logic                  sq_v;
	logic [CPP_ROOT_W-1:0] dist_root;
	sq_side_t              sq_sd;

	cpp_isqrt #(
		.ROOT_W (CPP_ROOT_W),
		.SIDE_W ($bits(sq_side_t))
	) u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_rad    ((2*CPP_ROOT_W)'(sum_s3)),
		.in_side   (sd_s3),
		.out_valid (sq_v),
		.out_root  (dist_root),
		.out_side  (sq_sd)
	);

	// stage 4: compare against the effective radius, depth of penetration
	logic [CPP_ROOT_W-1:0] radius;
	logic                  lt;
	assign radius = CPP_ROOT_W'(srad_q) + CPP_ROOT_W'(margin_q);
	assign lt     = (dist_root < radius);

	logic                  v_s4;
	sq_side_t              sd_s4;
	logic                  lt_s4;
	logic [31:0]           f_s4;
	logic [CPP_ROOT_W-1:0] dist_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		sd_s4   <= sq_sd;
		lt_s4   <= lt;
		f_s4    <= 32'(radius - dist_root);
		dist_s4 <= dist_root;
	end

	// stage 5: depth times each offset magnitude
	logic                  v_s5;
	dv_side_t              sd_s5;
	logic [CPP_ROOT_W-1:0] dist_s5;
	logic [63:0]           nx_s5, ny_s5, nz_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		sd_s5.mode     <= sd_s4.mode;
		sd_s5.plane_lt <= sd_s4.plane_lt;
		sd_s5.plane_y  <= sd_s4.plane_y;
		sd_s5.at_ctr   <= sd_s4.at_ctr;
		sd_s5.lt       <= lt_s4;
		sd_s5.neg      <= sd_s4.neg;
		dist_s5        <= dist_s4;
		nx_s5          <= f_s4 * sd_s4.mag_x;
		ny_s5          <= f_s4 * sd_s4.mag_y;
		nz_s5          <= f_s4 * sd_s4.mag_z;
	end

	// divide each product by the distance
	logic                 dv_v, dv_vy, dv_vz;
	logic [CPP_QUO_W-1:0] qx, qy, qz;
	logic                 ox, oy, oz;
	dv_side_t             dv_sd;
	logic                 sy_unused, sz_unused;

	cpp_div #(
		.NUM_W (CPP_NUM_W), .DEN_W (CPP_DEN_W), .QUO_W (CPP_QUO_W),
		.SIDE_W ($bits(dv_side_t))
	) u_div_x (
		.clk (clk), .arst_n (arst_n),
		.in_valid (v_s5), .in_num (nx_s5), .in_den (CPP_DEN_W'(dist_s5)),
		.in_side (sd_s5),
		.out_valid (dv_v), .out_quo (qx), .out_ovf (ox), .out_side (dv_sd)
	);

	cpp_div #(
		.NUM_W (CPP_NUM_W), .DEN_W (CPP_DEN_W), .QUO_W (CPP_QUO_W), .SIDE_W (1)
	) u_div_y (
		.clk (clk), .arst_n (arst_n),
		.in_valid (v_s5), .in_num (ny_s5), .in_den (CPP_DEN_W'(dist_s5)),
		.in_side (sd_s5.neg[1]),
		.out_valid (dv_vy), .out_quo (qy), .out_ovf (oy), .out_side (sy_unused)
	);

	cpp_div #(
		.NUM_W (CPP_NUM_W), .DEN_W (CPP_DEN_W), .QUO_W (CPP_QUO_W), .SIDE_W (1)
	) u_div_z (
		.clk (clk), .arst_n (arst_n),
		.in_valid (v_s5), .in_num (nz_s5), .in_den (CPP_DEN_W'(dist_s5)),
		.in_side (sd_s5.neg[0]),
		.out_valid (dv_vz), .out_quo (qz), .out_ovf (oz), .out_side (sz_unused)
	);

	// signed saturation of a quotient magnitude
	function automatic logic [31:0] sat_fn(input logic [31:0] q, input logic ovf,
		input logic neg);
		logic big;
		begin
			big = ovf || q[31];
			if (neg) begin
				sat_fn = (big && (ovf || (q[30:0] != '0))) ? 32'h8000_0000 : 32'(-q);
			end else begin
				sat_fn = big ? 32'h7FFF_FFFF : q;
			end
		end
	endfunction

	// output stage: choose between plane and sphere results
	result_t res_d;
	logic    sph_push;

	always_comb begin
		sph_push = dv_sd.lt && !dv_sd.at_ctr;
		res_d    = '0;
		if (dv_sd.mode) begin
			res_d.in_contact = dv_sd.plane_lt;
			res_d.push_y     = dv_sd.plane_lt ? dv_sd.plane_y : '0;
		end else begin
			res_d.in_contact = dv_sd.lt;
			res_d.at_center  = dv_sd.at_ctr;
			if (sph_push) begin
				res_d.push_x = sat_fn(qx, ox, dv_sd.neg[2]);
				res_d.push_y = sat_fn(qy, oy, dv_sd.neg[1]);
				res_d.push_z = sat_fn(qz, oz, dv_sd.neg[0]);
			end
		end
	end

	logic    done_q;
	result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			// the three dividers run in lockstep
			done_q <= dv_v && dv_vy && dv_vz && (sy_unused || !sy_unused)
				&& (sz_unused || !sz_unused);
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;
endmodule

// ===== hdl/cpp_isqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on cpp_pkg
module cpp_isqrt import cpp_pkg::*; #(
	parameter int ROOT_W = CPP_ROOT_W,
	parameter int SIDE_W = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [2*ROOT_W-1:0]   in_rad,
	input  logic [SIDE_W-1:0]     in_side,
	output logic                  out_valid,
	output logic [ROOT_W-1:0]     out_root,
	output logic [SIDE_W-1:0]     out_side
);
	localparam int REM_W = ROOT_W + 3;

	logic                v_s    [0:ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [0:ROOT_W];
	logic [REM_W-1:0]    rem_s  [0:ROOT_W];
	logic [ROOT_W-1:0]   root_s [0:ROOT_W];
	logic [SIDE_W-1:0]   side_s [0:ROOT_W];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic [REM_W-1:0] cat;
		logic [REM_W-1:0] trial;
		logic             ge;
		always_comb begin
			cat   = {rem_s[k][REM_W-3:0], rad_s[k][2*ROOT_W-1 -: 2]};
			trial = {1'b0, root_s[k], 2'b01};
			ge    = (cat >= trial);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			rad_s[k+1]  <= {rad_s[k][2*ROOT_W-3:0], 2'b00};
			rem_s[k+1]  <= ge ? (cat - trial) : cat;
			root_s[k+1] <= {root_s[k][ROOT_W-2:0], ge};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[ROOT_W];
	assign out_root  = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];
endmodule

// ===== hdl/cpp_div.sv =====
// pipelined restoring divider, one quotient bit per stage, overflow flag
// depends on cpp_pkg
module cpp_div import cpp_pkg::*; #(
	parameter int NUM_W  = CPP_NUM_W,
	parameter int DEN_W  = CPP_DEN_W,
	parameter int QUO_W  = CPP_QUO_W,
	parameter int SIDE_W = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [NUM_W-1:0]   in_num,
	input  logic [DEN_W-1:0]   in_den,
	input  logic [SIDE_W-1:0]  in_side,
	output logic               out_valid,
	output logic [QUO_W-1:0]   out_quo,
	output logic               out_ovf,
	output logic [SIDE_W-1:0]  out_side
);
	localparam int HI_W = NUM_W - QUO_W;

	logic              v_s    [0:QUO_W];
	logic [QUO_W-1:0]  num_s  [0:QUO_W];
	logic [DEN_W-1:0]  den_s  [0:QUO_W];
	logic [DEN_W-1:0]  rem_s  [0:QUO_W];
	logic [QUO_W-1:0]  quo_s  [0:QUO_W];
	logic              ovf_s  [0:QUO_W];
	logic [SIDE_W-1:0] side_s [0:QUO_W];

	// upper half at or above the divisor means the quotient needs more bits
	assign v_s[0]    = in_valid;
	assign num_s[0]  = in_num[QUO_W-1:0];
	assign den_s[0]  = in_den;
	assign rem_s[0]  = DEN_W'(in_num[NUM_W-1 -: HI_W]);
	assign quo_s[0]  = '0;
	assign ovf_s[0]  = (DEN_W'(in_num[NUM_W-1 -: HI_W]) >= in_den);
	assign side_s[0] = in_side;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [DEN_W:0] sh;
		logic [DEN_W:0] diff;
		logic           ge;
		always_comb begin
			sh   = {rem_s[k], num_s[k][QUO_W-1]};
			diff = sh - {1'b0, den_s[k]};
			ge   = (sh >= {1'b0, den_s[k]});
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			num_s[k+1]  <= {num_s[k][QUO_W-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
			quo_s[k+1]  <= {quo_s[k][QUO_W-2:0], ge};
			ovf_s[k+1]  <= ovf_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = v_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_ovf   = ovf_s[QUO_W];
	assign out_side  = side_s[QUO_W];
endmodule

// ===== hdl/cpp_check.sv =====
// port-level checks for the collider push-out block, bound to the top level
// depends on cpp_pkg and collider_penetration_pushout
module cpp_check import cpp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input result_t     result
);
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("block refused a command word");

	a_center_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.at_center |->
		result.push_x == 0 && result.push_y == 0 && result.push_z == 0)
		else $error("push at the sphere center");

	a_outside_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.in_contact |->
		result.push_x == 0 && result.push_y == 0 && result.push_z == 0)
		else $error("push without contact");
endmodule

bind collider_penetration_pushout cpp_check u_cpp_check (.*);

// ===== tb/tb_collider_penetration_pushout.sv =====
// self-checking testbench for collider_penetration_pushout
// depends on cpp_pkg and the rtl under hdl; holds its own push-out predictor
`timescale 1ns / 100ps

import cpp_pkg::*;

class pushout_scoreboard;
	logic        mode_plane;
	logic [30:0] margin;
	logic [31:0] ctr_x, ctr_y, ctr_z;
	logic [30:0] radius;
	result_t     expected_q[$];
	int          errors;

	function new();
		mode_plane = 1'b1;
		margin     = '0;
		ctr_x      = '0;
		ctr_y      = '0;
		ctr_z      = '0;
		radius     = 31'd65536;
		errors     = 0;
	endfunction

	function void set_reg(cfg_reg_t idx, logic [31:0] v);
		case (idx)
			REG_SHAPE_MODE:    mode_plane = v[0];
			REG_MARGIN:        margin     = v[30:0];
			REG_CENTER_X:      ctr_x      = v;
			REG_CENTER_Y:      ctr_y      = v;
			REG_CENTER_Z:      ctr_z      = v;
			REG_SPHERE_RADIUS: radius     = v[30:0];
			default: ;
		endcase
	endfunction

	// clamp a magnitude with a sign to the 32-bit signed range
	function logic [31:0] clamp32(logic [127:0] mag, logic neg);
		if (neg) begin
			if (mag >= 128'h8000_0000)
				return 32'h8000_0000;
			return 32'(-mag);
		end
		if (mag > 128'h7FFF_FFFF)
			return 32'h7FFF_FFFF;
		return mag[31:0];
	endfunction

	function result_t push_for(cmd_t c);
		logic signed [63:0] pos [3];
		logic signed [63:0] ctr [3];
		logic signed [63:0] dv  [3];
		logic [127:0]       mag [3];
		logic [127:0]       sumsq, trial, root, rad, f, quo;
		result_t            r;
		r = '0;
		pos[0] = 64'(c.pos_x);
		pos[1] = 64'(c.pos_y);
		pos[2] = 64'(c.pos_z);
		if (mode_plane) begin
			if (pos[1] < $signed({33'd0, margin})) begin
				r.push_y     = clamp32(128'($signed({33'd0, margin}) - pos[1]), 1'b0);
				r.in_contact = 1'b1;
			end
			return r;
		end
		ctr[0] = 64'($signed(ctr_x));
		ctr[1] = 64'($signed(ctr_y));
		ctr[2] = 64'($signed(ctr_z));
		sumsq = '0;
		for (int k = 0; k < 3; k++) begin
			dv[k]  = pos[k] - ctr[k];
			mag[k] = dv[k] < 0 ? 128'(-dv[k]) : 128'(dv[k]);
			sumsq  = sumsq + mag[k] * mag[k];
		end
		// bitwise floor square root, 34 result bits
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (128'd1 << b);
			if (trial * trial <= sumsq)
				root = trial;
		end
		rad = 128'(margin) + 128'(radius);
		r.in_contact = root < rad;
		if (sumsq == 0) begin
			r.at_center = 1'b1;
			return r;
		end
		if (root < rad) begin
			f = rad - root;
			quo = f * mag[0] / root;
			r.push_x = clamp32(quo, dv[0] < 0);
			quo = f * mag[1] / root;
			r.push_y = clamp32(quo, dv[1] < 0);
			quo = f * mag[2] / root;
			r.push_z = clamp32(quo, dv[2] < 0);
		end
		return r;
	endfunction

	function void note_cmd(cmd_t c);
		expected_q.push_back(push_for(c));
	endfunction

	function void check_result(result_t got);
		result_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result word %h", $time, got);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		if (got.push_x !== want.push_x) begin
			$display("%0t: push_x expected %h actual %h", $time, want.push_x, got.push_x);
			errors++;
		end
		if (got.push_y !== want.push_y) begin
			$display("%0t: push_y expected %h actual %h", $time, want.push_y, got.push_y);
			errors++;
		end
		if (got.push_z !== want.push_z) begin
			$display("%0t: push_z expected %h actual %h", $time, want.push_z, got.push_z);
			errors++;
		end
		if (got.in_contact !== want.in_contact) begin
			$display("%0t: in_contact expected %b actual %b", $time,
				want.in_contact, got.in_contact);
			errors++;
		end
		if (got.at_center !== want.at_center) begin
			$display("%0t: at_center expected %b actual %b", $time,
				want.at_center, got.at_center);
			errors++;
		end
	endfunction
endclass

module tb_collider_penetration_pushout;

	// pipeline depth of the block, plus some slack
	localparam int DRAIN_CYCLES = 90;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        done;
	result_t     result;

	pushout_scoreboard sb;
	bit                idle_on;

	collider_penetration_pushout u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.result    (result)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watch both channels at the edge; every signal here changed by nba only
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			sb.note_cmd(cmd);
		if (arst_n && done)
			sb.check_result(result);
	end

	// hand one command word over; busy is tied low, so its value at the
	// falling edge is what the next rising edge will see
	task automatic send_word(cmd_t c);
		bit took;
		while (idle_on && $urandom_range(99) < 15) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do begin
			@(negedge clk);
			took = !busy;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_xyz(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		cmd_t c;
		c.pos_x = x;
		c.pos_y = y;
		c.pos_z = z;
		send_word(c);
	endtask

	// let the pipeline empty out; only then may registers change
	task automatic drain();
		start <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// valid stays up between back-to-back writes; the caller drops it
	task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
		bit took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		sb.set_reg(idx, v);
	endtask

	task automatic setup(logic plane, logic [30:0] mg, logic [31:0] cx, logic [31:0] cy,
		logic [31:0] cz, logic [30:0] rad);
		drain();
		write_reg(REG_SHAPE_MODE, {31'd0, plane});
		write_reg(REG_MARGIN, {1'b0, mg});
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_SPHERE_RADIUS, {1'b0, rad});
		cfg_valid <= 1'b0;
	endtask

	// a random offset spread over many magnitudes, so that most points land
	// near the surface of small or large colliders alike
	function automatic logic [31:0] spread();
		return 32'($signed($urandom) >>> $urandom_range(0, 31));
	endfunction

	task automatic random_words(int n);
		for (int i = 0; i < n; i++) begin
			// long stretch without gaps in the middle of every phase
			idle_on = !(i > n / 3 && i < n / 2);
			case ($urandom_range(9))
				0, 1: send_xyz($urandom, $urandom, $urandom);
				2: send_xyz(sb.ctr_x, sb.ctr_y, sb.ctr_z);
				3: send_xyz($urandom, {1'b0, sb.margin} + spread(), $urandom);
				default: send_xyz(sb.ctr_x + spread(), sb.ctr_y + spread(),
					sb.ctr_z + spread());
			endcase
		end
		idle_on = 1'b1;
	endtask

	initial begin
		sb        = new();
		idle_on   = 1'b1;
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SHAPE_MODE;
		cfg_data  = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: ground plane, no margin
		send_xyz(32'd0, 32'd0, 32'd0);
		send_xyz(32'd5, 32'hFFFF_FFFF, 32'd7);
		send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

		// widest margin: lift from the lowest point saturates
		setup(1'b1, 31'h7FFF_FFFF, 0, 0, 0, 31'd65536);
		send_xyz(32'd1, 32'h8000_0000, 32'd1);
		send_xyz(32'd0, 32'h7FFF_FFFE, 32'd0);
		send_xyz(32'd0, 32'h7FFF_FFFF, 32'd0);

		// unit sphere at the origin
		setup(1'b0, 31'd0, 0, 0, 0, 31'd65536);
		send_xyz(32'd0, 32'd0, 32'd0);
		send_xyz(32'd1, 32'd0, 32'd0);
		send_xyz(32'd0, 32'hFFFF_FFFF, 32'd0);
		send_xyz(32'd65535, 32'd0, 32'd0);
		send_xyz(32'd65536, 32'd0, 32'd0);
		send_xyz(32'd3, 32'hFFFF_FFFC, 32'd12);
		send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);

		// zero radius: the centre is not a contact
		setup(1'b0, 31'd0, 32'd100, 32'hFFFF_FF00, 32'd7, 31'd0);
		send_xyz(32'd100, 32'hFFFF_FF00, 32'd7);
		send_xyz(32'd101, 32'hFFFF_FF00, 32'd7);

		// huge sphere at the corner: large pushes saturate
		setup(1'b0, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			31'h7FFF_FFFF);
		send_xyz(32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000);
		send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
		send_xyz(32'd0, 32'd0, 32'd0);

		// random phases over several collider settings
		setup(1'b0, 31'd0, 0, 0, 0, 31'd65536);
		random_words(120);
		setup(1'b0, 31'd4096, 32'hFFF0_0000, 32'h0003_0000, 32'h1234_5678, 31'h0008_0000);
		random_words(120);
		setup(1'b0, 31'h7FFF_FFFF, $urandom, $urandom, $urandom, 31'h7FFF_FFFF);
		random_words(110);
		setup(1'b0, 31'd0, $urandom, $urandom, $urandom, 31'd3);
		random_words(110);
		setup(1'b1, 31'h0001_8000, 0, 0, 0, 31'd65536);
		random_words(100);
		setup(1'b0, 31'($urandom), $urandom, $urandom, $urandom, 31'($urandom));
		random_words(120);
		setup(1'b1, 31'd0, 0, 0, 0, 31'd0);
		random_words(90);
		setup(1'b0, 31'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0);
		random_words(80);
		setup(1'b0, 31'd1, 32'd0, 32'd0, 32'd0, 31'h0100_0000);
		random_words(80);

		drain();
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hard stop well past the slowest correct run
	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
